>>> rtl/core/matrix3x3_inverse_defines.svh
// Assertion macros shared by the matrix inverse RTL.
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

`ifndef SYNTHESIS
// Implication in the same cycle, checked on clk, off while rst_n is low
`define M3I_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m3i assertion failed");
// Implication into the next cycle
`define M3I_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m3i assertion failed");
`else
`define M3I_ASSERT_IMP(lbl, ante, cons)
`define M3I_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/m3i_pkg.sv
// Types, constants and helpers for the 3x3 matrix inverse pipeline.
`default_nettype none
package m3i_pkg;

  localparam int unsigned ELEM_W  = 32;
  localparam int unsigned N_ELEM  = 9;
  localparam int unsigned CMAG_W  = 64;
  localparam int unsigned TERM_W  = 97;
  localparam int unsigned DET_W   = 98;
  localparam int unsigned Q_STEPS = 32;

  // Cofactor k = e[a]*e[b] - e[c]*e[d], row-major element indexes
  localparam int unsigned COF_IDX [N_ELEM][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic [N_ELEM-1:0][ELEM_W-1:0] elem_vec_t;

  // Payload carried through the quotient pipeline
  typedef struct packed {
    elem_vec_t                         elem;
    logic [N_ELEM-1:0][DET_W-1:0]      rem;
    logic [N_ELEM-1:0][ELEM_W-1:0]     quo;
    logic [N_ELEM-1:0]                 cneg;
    logic [N_ELEM-1:0]                 ovf;
    logic [DET_W-1:0]                  dmag;
    logic                              dneg;
    logic                              sing;
  } m3i_div_t;

  function automatic logic signed [63:0] mul_s32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    mul_s32 = 64'(a) * 64'(b);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/m3i_div_stage.sv
// One restoring-division step for all nine lanes, with its own pipeline register.
`default_nettype none
module m3i_div_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire m3i_pkg::m3i_div_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output m3i_pkg::m3i_div_t     out_data
);
  import m3i_pkg::*;

  logic      valid_r;
  m3i_div_t  data_r;
  m3i_div_t  data_nxt;

  // Shift remainder, subtract divisor when it fits, shift in quotient bit
  always_comb begin
    data_nxt = in_data;
    for (int k = 0; k < N_ELEM; k++) begin
      logic [DET_W:0] trial;
      trial = {in_data.rem[k], 1'b0};
      if (trial >= {1'b0, in_data.dmag}) begin
        data_nxt.rem[k] = DET_W'(trial - {1'b0, in_data.dmag});
        data_nxt.quo[k] = {in_data.quo[k][ELEM_W-2:0], 1'b1};
      end else begin
        data_nxt.rem[k] = trial[DET_W-1:0];
        data_nxt.quo[k] = {in_data.quo[k][ELEM_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Advance when downstream has room
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule
`default_nettype wire

>>> rtl/core/matrix3x3_inverse.sv
// Top level: pipelined 3x3 Q16.16 matrix inverse by the adjugate method.
//
// Input channel in_valid/in_ready carries one matrix as nine signed Q16.16
// entries, row-major. Output channel out_valid/out_ready carries the nine
// inverse entries plus the singular and saturated flags.
// A transaction can enter every cycle while in_ready is high; throughput is
// one matrix per clock while the receiver does not stall. The pipeline has
// 7 stages for cofactor products, determinant, magnitude and divider setup,
// 32 stages of a shared-step restoring divider (one quotient bit per stage
// for all nine lanes), then the saturating output register.
// A zero determinant echoes the input with singular set and saturated clear.
// Every stage has its own valid bit; a stalled receiver holds the output
// register and the stall backs up stage by stage, so empty stages keep
// filling and in_ready drops only when every stage holds a transaction.
// Reset (rst_n low, synchronous) empties the pipeline; nothing else is kept.
`default_nettype none
`include "matrix3x3_inverse_defines.svh"
module matrix3x3_inverse (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_elem_r0c0,
  input  wire logic [31:0] in_elem_r0c1,
  input  wire logic [31:0] in_elem_r0c2,
  input  wire logic [31:0] in_elem_r1c0,
  input  wire logic [31:0] in_elem_r1c1,
  input  wire logic [31:0] in_elem_r1c2,
  input  wire logic [31:0] in_elem_r2c0,
  input  wire logic [31:0] in_elem_r2c1,
  input  wire logic [31:0] in_elem_r2c2,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_inv_r0c0,
  output logic [31:0]      out_inv_r0c1,
  output logic [31:0]      out_inv_r0c2,
  output logic [31:0]      out_inv_r1c0,
  output logic [31:0]      out_inv_r1c1,
  output logic [31:0]      out_inv_r1c2,
  output logic [31:0]      out_inv_r2c0,
  output logic [31:0]      out_inv_r2c1,
  output logic [31:0]      out_inv_r2c2,
  output logic             out_singular,
  output logic             out_saturated
);
  import m3i_pkg::*;

  elem_vec_t in_elem;

  assign in_elem[0] = in_elem_r0c0;
  assign in_elem[1] = in_elem_r0c1;
  assign in_elem[2] = in_elem_r0c2;
  assign in_elem[3] = in_elem_r1c0;
  assign in_elem[4] = in_elem_r1c1;
  assign in_elem[5] = in_elem_r1c2;
  assign in_elem[6] = in_elem_r2c0;
  assign in_elem[7] = in_elem_r2c1;
  assign in_elem[8] = in_elem_r2c2;

  // Stage valid bits and ready chain
  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, s6_v_r, s7_v_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, s6_rdy, s7_rdy;
  logic out_valid_r, fin_rdy;

  logic     [Q_STEPS:0] div_v;
  logic     [Q_STEPS:0] div_rdy;
  m3i_div_t             div_d [Q_STEPS+1];

  assign fin_rdy = !out_valid_r || out_ready;
  assign s7_rdy  = !s7_v_r || div_rdy[0];
  assign s6_rdy  = !s6_v_r || s7_rdy;
  assign s5_rdy  = !s5_v_r || s6_rdy;
  assign s4_rdy  = !s4_v_r || s5_rdy;
  assign s3_rdy  = !s3_v_r || s4_rdy;
  assign s2_rdy  = !s2_v_r || s3_rdy;
  assign s1_rdy  = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_r <= in_valid;
      if (s2_rdy) s2_v_r <= s1_v_r;
      if (s3_rdy) s3_v_r <= s2_v_r;
      if (s4_rdy) s4_v_r <= s3_v_r;
      if (s5_rdy) s5_v_r <= s4_v_r;
      if (s6_rdy) s6_v_r <= s5_v_r;
      if (s7_rdy) s7_v_r <= s6_v_r;
      if (fin_rdy) out_valid_r <= div_v[Q_STEPS];
    end
  end

  // Stage 1: the eighteen 2x2 minor products
  elem_vec_t                     s1_elem_r;
  logic [N_ELEM-1:0][63:0]       s1_p_r, s1_q_r, s1_p_nxt, s1_q_nxt;

  for (genvar k = 0; k < N_ELEM; k++) begin : g_minor
    assign s1_p_nxt[k] = mul_s32(in_elem[COF_IDX[k][0]], in_elem[COF_IDX[k][1]]);
    assign s1_q_nxt[k] = mul_s32(in_elem[COF_IDX[k][2]], in_elem[COF_IDX[k][3]]);
  end

  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_elem_r <= in_elem;
      s1_p_r    <= s1_p_nxt;
      s1_q_r    <= s1_q_nxt;
    end
  end

  // Stage 2: cofactors
  elem_vec_t               s2_elem_r;
  logic [N_ELEM-1:0][63:0] s2_adj_r;

  always_ff @(posedge clk) begin
    if (s2_rdy && s1_v_r) begin
      s2_elem_r <= s1_elem_r;
      for (int k = 0; k < N_ELEM; k++) begin
        s2_adj_r[k] <= s1_p_r[k] - s1_q_r[k];
      end
    end
  end

  // Stage 3: split 32x64 determinant products, cofactor magnitudes
  elem_vec_t                   s3_elem_r;
  logic [2:0][64:0]            s3_pl_r, s3_pl_nxt;
  logic [2:0][63:0]            s3_ph_r, s3_ph_nxt;
  logic [N_ELEM-1:0][CMAG_W-1:0] s3_cmag_r;
  logic [N_ELEM-1:0]           s3_cneg_r;

  for (genvar j = 0; j < 3; j++) begin : g_part
    assign s3_pl_nxt[j] = 65'($signed(s2_elem_r[j]))
                        * 65'($signed({1'b0, s2_adj_r[3*j][31:0]}));
    assign s3_ph_nxt[j] = mul_s32(s2_elem_r[j], s2_adj_r[3*j][63:32]);
  end

  always_ff @(posedge clk) begin
    if (s3_rdy && s2_v_r) begin
      s3_elem_r <= s2_elem_r;
      s3_pl_r   <= s3_pl_nxt;
      s3_ph_r   <= s3_ph_nxt;
      for (int k = 0; k < N_ELEM; k++) begin
        s3_cneg_r[k] <= s2_adj_r[k][63];
        s3_cmag_r[k] <= s2_adj_r[k][63] ? (~s2_adj_r[k] + 64'd1) : s2_adj_r[k];
      end
    end
  end

  // Stage 4: recombine partial products into full terms
  elem_vec_t                     s4_elem_r;
  logic [2:0][TERM_W-1:0]        s4_term_r;
  logic [N_ELEM-1:0][CMAG_W-1:0] s4_cmag_r;
  logic [N_ELEM-1:0]             s4_cneg_r;

  always_ff @(posedge clk) begin
    if (s4_rdy && s3_v_r) begin
      s4_elem_r <= s3_elem_r;
      s4_cmag_r <= s3_cmag_r;
      s4_cneg_r <= s3_cneg_r;
      for (int j = 0; j < 3; j++) begin
        s4_term_r[j] <= {s3_ph_r[j][63], s3_ph_r[j], 32'b0}
                      + {{32{s3_pl_r[j][64]}}, s3_pl_r[j]};
      end
    end
  end

  // Stage 5: determinant
  elem_vec_t                     s5_elem_r;
  logic [DET_W-1:0]              s5_det_r;
  logic [N_ELEM-1:0][CMAG_W-1:0] s5_cmag_r;
  logic [N_ELEM-1:0]             s5_cneg_r;

  always_ff @(posedge clk) begin
    if (s5_rdy && s4_v_r) begin
      s5_elem_r <= s4_elem_r;
      s5_cmag_r <= s4_cmag_r;
      s5_cneg_r <= s4_cneg_r;
      s5_det_r  <= {s4_term_r[0][TERM_W-1], s4_term_r[0]}
                 + {s4_term_r[1][TERM_W-1], s4_term_r[1]}
                 + {s4_term_r[2][TERM_W-1], s4_term_r[2]};
    end
  end

  // Stage 6: determinant sign, magnitude and zero test
  elem_vec_t                     s6_elem_r;
  logic [DET_W-1:0]              s6_dmag_r;
  logic                          s6_dneg_r, s6_sing_r;
  logic [N_ELEM-1:0][CMAG_W-1:0] s6_cmag_r;
  logic [N_ELEM-1:0]             s6_cneg_r;

  always_ff @(posedge clk) begin
    if (s6_rdy && s5_v_r) begin
      s6_elem_r <= s5_elem_r;
      s6_cmag_r <= s5_cmag_r;
      s6_cneg_r <= s5_cneg_r;
      s6_dneg_r <= s5_det_r[DET_W-1];
      s6_sing_r <= (s5_det_r == '0);
      s6_dmag_r <= s5_det_r[DET_W-1] ? (~s5_det_r + DET_W'(1)) : s5_det_r;
    end
  end

  // Stage 7: overflow test and divider setup
  m3i_div_t s7_d_r, s7_d_nxt;

  always_comb begin
    s7_d_nxt.elem = s6_elem_r;
    s7_d_nxt.cneg = s6_cneg_r;
    s7_d_nxt.dmag = s6_dmag_r;
    s7_d_nxt.dneg = s6_dneg_r;
    s7_d_nxt.sing = s6_sing_r;
    s7_d_nxt.quo  = '0;
    for (int k = 0; k < N_ELEM; k++) begin
      s7_d_nxt.rem[k] = {{(DET_W-CMAG_W){1'b0}}, s6_cmag_r[k]};
      s7_d_nxt.ovf[k] = ({{(DET_W-CMAG_W){1'b0}}, s6_cmag_r[k]} >= s6_dmag_r);
    end
  end

  always_ff @(posedge clk) begin
    if (s7_rdy && s6_v_r) begin
      s7_d_r <= s7_d_nxt;
    end
  end

  // Quotient pipeline: one bit per stage
  assign div_v[0]         = s7_v_r;
  assign div_d[0]         = s7_d_r;
  assign div_rdy[Q_STEPS] = fin_rdy;

  for (genvar g = 0; g < Q_STEPS; g++) begin : g_div
    m3i_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[g]),
      .in_ready  (div_rdy[g]),
      .in_data   (div_d[g]),
      .out_valid (div_v[g+1]),
      .out_ready (div_rdy[g+1]),
      .out_data  (div_d[g+1])
    );
  end

  // Output stage: sign, saturate, singular bypass
  elem_vec_t fin_inv, out_inv_r;
  logic      fin_sat, out_sat_r, out_sing_r;

  always_comb begin
    m3i_div_t          f;
    logic [N_ELEM-1:0] lane_sat;
    f = div_d[Q_STEPS];
    for (int k = 0; k < N_ELEM; k++) begin
      logic        rneg;
      logic [31:0] limit, mag;
      rneg        = f.cneg[k] ^ f.dneg;
      limit       = rneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      lane_sat[k] = f.ovf[k] || (f.quo[k] > limit);
      mag         = lane_sat[k] ? limit : f.quo[k];
      fin_inv[k]  = rneg ? (~mag + 32'd1) : mag;
    end
    fin_sat = |lane_sat;
    if (f.sing) begin
      fin_inv = f.elem;
      fin_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_rdy && div_v[Q_STEPS]) begin
      out_inv_r  <= fin_inv;
      out_sat_r  <= fin_sat;
      out_sing_r <= div_d[Q_STEPS].sing;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_inv_r0c0  = out_inv_r[0];
  assign out_inv_r0c1  = out_inv_r[1];
  assign out_inv_r0c2  = out_inv_r[2];
  assign out_inv_r1c0  = out_inv_r[3];
  assign out_inv_r1c1  = out_inv_r[4];
  assign out_inv_r1c2  = out_inv_r[5];
  assign out_inv_r2c0  = out_inv_r[6];
  assign out_inv_r2c1  = out_inv_r[7];
  assign out_inv_r2c2  = out_inv_r[8];
  assign out_singular  = out_sing_r;
  assign out_saturated = out_sat_r;

  // Checks
  `M3I_ASSERT_IMP(a_sing_no_sat, out_valid && out_singular, !out_saturated)
  `M3I_ASSERT_IMP(a_full_on_stall, !in_ready, out_valid && !out_ready)
  `M3I_ASSERT_NXT(a_enter_stage1, in_valid && in_ready, s1_v_r)

endmodule
`default_nettype wire
